// ===== rtl/ics_pkg.sv =====
// ----------------------------------------------------------------------------
// ics_pkg: shared types and constants of the ion chromatogram slice
// Field widths, register indexes and the shared adder's operand bundles.
// ----------------------------------------------------------------------------
package ics_pkg;

   // fixed field widths
   localparam int MZ_W       = 28;
   localparam int INT_W      = 32;
   localparam int RT_W       = 24;
   localparam int LEVEL_W    = 4;
   localparam int SCAN_OUT_W = 20;
   localparam int PINT_W     = 40;
   localparam int TOTAL_W    = 48;
   localparam int WACC_W     = 64;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_MZ_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MZ_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RT_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RT_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MS_LEVEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd5;

   localparam logic MODE_MAX = 1'b0;
   localparam logic MODE_SUM = 1'b1;

   // shared adder/subtractor
   localparam int ALU_W = 64;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             carry;   // carry out; on subtract, 1 means a >= b
   } alu_rsp_type;

endpackage

// ===== rtl/ics_shared_alu.sv =====
// ----------------------------------------------------------------------------
// ics_shared_alu: shared adder/subtractor
// One 64-bit add or subtract with carry out, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module ics_shared_alu (
   input  ics_pkg::alu_req_type alu_req,
   output ics_pkg::alu_rsp_type alu_rsp
);
   import ics_pkg::*;

   logic [ALU_W:0] result;

   assign result = {1'b0, alu_req.a}
                 + {1'b0, alu_req.b ^ {ALU_W{alu_req.sub}}}
                 + {{ALU_W{1'b0}}, alu_req.sub};

   assign alu_rsp.sum   = result[ALU_W-1:0];
   assign alu_rsp.carry = result[ALU_W];

endmodule

// ===== rtl/ion_chromatogram_slice.sv =====
// ----------------------------------------------------------------------------
// ion_chromatogram_slice: extracted ion chromatogram, one point per passing scan
// Filters centroids by an m/z window, reduces each scan to max or sum with
// weighted mean m/z, and emits a point with running total and maximum.
// ----------------------------------------------------------------------------
//
//  channel | ports     | direction | moves
//  --------+-----------+-----------+-----------------------------------------
//  request | req_*     | in        | one centroid item (or empty-scan marker)
//  result  | rsp_*     | out       | one trace point item per passing scan
//  config  | csr_*     | in        | register writes, always ready
//
//  Per item: an item outside the window or in max mode is only evaluated;
//  in sum mode a shift-add multiply (one mz bit per cycle, on the shared
//  adder) and an accumulate step follow. A scan end adds an end step, the
//  sum-mode weighted mean division (restoring, one quotient bit per cycle on
//  the same adder) and the emit step. Reset: synchronous; no clearing pass.
//  Stalls: the result sits in an output register, so new items are taken
//  while it waits; only the emit step holds while that register is full.
//  Once stopped, items are taken and dropped at one per cycle.
//
module ion_chromatogram_slice #(
   parameter int INTENSITY_BITS  = 32,
   parameter int MZ_BITS         = 28,
   parameter int SCAN_INDEX_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_has_peak,
   input  logic [ics_pkg::MZ_W-1:0]          req_peak_mz,
   input  logic [ics_pkg::INT_W-1:0]         req_peak_intensity,
   input  logic [ics_pkg::RT_W-1:0]          req_scan_rt,
   input  logic [ics_pkg::LEVEL_W-1:0]       req_scan_level,
   input  logic                              req_scan_end,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ics_pkg::SCAN_OUT_W-1:0]    rsp_scan_index,
   output logic [ics_pkg::RT_W-1:0]          rsp_point_rt,
   output logic [ics_pkg::PINT_W-1:0]        rsp_point_intensity,
   output logic [ics_pkg::MZ_W-1:0]          rsp_point_mz,
   output logic [ics_pkg::TOTAL_W-1:0]       rsp_running_total,
   output logic [ics_pkg::PINT_W-1:0]        rsp_running_max,
   output logic                              rsp_saturated,
   // configuration port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ics_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ics_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ics_pkg::*;

   // effective widths: fields are masked to the narrower of port and parameter
   localparam int IW = (INTENSITY_BITS < INT_W) ? INTENSITY_BITS : INT_W;
   localparam int MZW = (MZ_BITS < MZ_W) ? MZ_BITS : MZ_W;
   localparam int PW = IW + MZW;
   localparam int SW = SCAN_INDEX_BITS;
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MZW - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_END  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_TOT  = 3'd6;

   // control and state (reset)
   logic [2:0]         state_ff, state_in;
   logic [MZ_W-1:0]    mz_low_ff, mz_low_in;
   logic [MZ_W-1:0]    mz_high_ff, mz_high_in;
   logic [RT_W-1:0]    rt_low_ff, rt_low_in;
   logic [RT_W-1:0]    rt_high_ff, rt_high_in;
   logic [LEVEL_W-1:0] ms_level_ff, ms_level_in;
   logic               mode_ff, mode_in;
   logic [SW-1:0]      counter_ff, counter_in;
   logic [PINT_W-1:0]  best_ff, best_in;
   logic [MZ_W-1:0]    best_mz_ff, best_mz_in;
   logic [WACC_W-1:0]  weighted_ff, weighted_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [PINT_W-1:0]  max_seen_ff, max_seen_in;
   logic               stopped_ff, stopped_in;
   logic               sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload and work registers (no reset)
   logic               has_peak_ff, has_peak_in;
   logic [MZW-1:0]     mz_ff, mz_in;
   logic [IW-1:0]      inten_ff, inten_in;
   logic [RT_W-1:0]    rt_ff, rt_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               end_ff, end_in;
   logic [PW:0]        prod_ff, prod_in;     // {hi carry+IW, lo MZW}
   logic [PINT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [MZ_W-1:0]    pmz_ff, pmz_in;

   // output register payload
   logic [SCAN_OUT_W-1:0] o_idx_ff, o_idx_in;
   logic [RT_W-1:0]       o_rt_ff, o_rt_in;
   logic [PINT_W-1:0]     o_pint_ff, o_pint_in;
   logic [MZ_W-1:0]       o_pmz_ff, o_pmz_in;
   logic [TOTAL_W-1:0]    o_total_ff, o_total_in;
   logic [PINT_W-1:0]     o_max_ff, o_max_in;
   logic                  o_sat_ff, o_sat_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic [MZ_W-1:0]  mz_full;
   logic             in_window;
   logic [IW:0]      mul_hi;
   logic [PINT_W:0]  rem_shift;
   logic             div_ge;
   logic             sum_ovf40;
   logic             sum_ovf48;
   logic             slot_free;

   ics_shared_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign mz_full   = MZ_W'(mz_ff);
   assign in_window = has_peak_ff && (mz_full >= mz_low_ff) && (mz_full <= mz_high_ff);
   assign rem_shift = {rem_ff, weighted_ff[WACC_W-1]};
   assign div_ge    = alu_rsp.carry;
   assign sum_ovf40 = |alu_rsp.sum[ALU_W-1:PINT_W];
   assign sum_ovf48 = |alu_rsp.sum[ALU_W-1:TOTAL_W];
   assign mul_hi    = prod_ff[0] ? alu_rsp.sum[IW:0] : prod_ff[PW:MZW];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // operand select for the shared adder
   always_comb begin
      alu_req = '0;
      case (state_ff)
         S_EVAL: begin
            alu_req.a = ALU_W'(best_ff);
            alu_req.b = ALU_W'(inten_ff);
         end
         S_MUL: begin
            alu_req.a = ALU_W'(prod_ff[PW:MZW]);
            alu_req.b = ALU_W'(inten_ff);
         end
         S_ACC: begin
            alu_req.a = weighted_ff;
            alu_req.b = ALU_W'(prod_ff[PW-1:0]);
         end
         S_DIV: begin
            alu_req.a   = ALU_W'(rem_shift);
            alu_req.b   = ALU_W'(best_ff);
            alu_req.sub = 1'b1;
         end
         S_TOT: begin
            alu_req.a = ALU_W'(total_ff);
            alu_req.b = ALU_W'(best_ff);
         end
         default: begin
            alu_req = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      mz_low_in   = mz_low_ff;
      mz_high_in  = mz_high_ff;
      rt_low_in   = rt_low_ff;
      rt_high_in  = rt_high_ff;
      ms_level_in = ms_level_ff;
      mode_in     = mode_ff;
      counter_in  = counter_ff;
      best_in     = best_ff;
      best_mz_in  = best_mz_ff;
      weighted_in = weighted_ff;
      total_in    = total_ff;
      max_seen_in = max_seen_ff;
      stopped_in  = stopped_ff;
      sat_in      = sat_ff;
      has_peak_in = has_peak_ff;
      mz_in       = mz_ff;
      inten_in    = inten_ff;
      rt_in       = rt_ff;
      level_in    = level_ff;
      end_in      = end_ff;
      prod_in     = prod_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      pmz_in      = pmz_ff;
      o_idx_in    = o_idx_ff;
      o_rt_in     = o_rt_ff;
      o_pint_in   = o_pint_ff;
      o_pmz_in    = o_pmz_ff;
      o_total_in  = o_total_ff;
      o_max_in    = o_max_ff;
      o_sat_in    = o_sat_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // register writes; to be issued only while idle, which the block itself does not enforce
      if (csr_valid) begin
         case (csr_index)
            CSR_MZ_LOW:   mz_low_in   = csr_data[MZ_W-1:0];
            CSR_MZ_HIGH:  mz_high_in  = csr_data[MZ_W-1:0];
            CSR_RT_LOW:   rt_low_in   = csr_data[RT_W-1:0];
            CSR_RT_HIGH:  rt_high_in  = csr_data[RT_W-1:0];
            CSR_MS_LEVEL: ms_level_in = csr_data[LEVEL_W-1:0];
            CSR_MODE:     mode_in     = csr_data[0];
            default:      ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            // once stopped, items are taken and dropped
            if (req_valid && !stopped_ff) begin
               has_peak_in = req_has_peak;
               mz_in       = req_peak_mz[MZW-1:0];
               inten_in    = req_peak_intensity[IW-1:0];
               rt_in       = req_scan_rt;
               level_in    = req_scan_level;
               end_in      = req_scan_end;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = end_ff ? S_END : S_IDLE;
            if (in_window) begin
               if (mode_ff == MODE_MAX) begin
                  // strict compare: first centroid wins on ties
                  if (PINT_W'(inten_ff) > best_ff) begin
                     best_in    = PINT_W'(inten_ff);
                     best_mz_in = mz_full;
                  end
               end else begin
                  best_in = sum_ovf40 ? {PINT_W{1'b1}} : alu_rsp.sum[PINT_W-1:0];
                  sat_in  = sat_ff | sum_ovf40;
                  prod_in = (PW + 1)'(mz_ff);
                  cnt_in  = MUL_LAST;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            // shift-add: one mz bit per cycle, intensity added to upper half
            prod_in = {1'b0, mul_hi, prod_ff[MZW-1:1]};
            if (cnt_ff == '0) begin
               state_in = S_ACC;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_ACC: begin
            if (alu_rsp.carry) begin
               weighted_in = {WACC_W{1'b1}};
               sat_in      = 1'b1;
            end else begin
               weighted_in = alu_rsp.sum;
            end
            state_in = end_ff ? S_END : S_IDLE;
         end
         S_END: begin
            idx_in     = counter_ff;
            counter_in = counter_ff + SW'(1);
            if ((level_ff != ms_level_ff) || (rt_ff < rt_low_ff)) begin
               best_in     = '0;
               best_mz_in  = '0;
               weighted_in = '0;
               sat_in      = 1'b0;
               state_in    = S_IDLE;
            end else if (rt_ff > rt_high_ff) begin
               stopped_in  = 1'b1;
               best_in     = '0;
               best_mz_in  = '0;
               weighted_in = '0;
               sat_in      = 1'b0;
               state_in    = S_IDLE;
            end else if ((mode_ff == MODE_SUM) && (best_ff != '0)) begin
               rem_in   = '0;
               cnt_in   = DIV_LAST;
               state_in = S_DIV;
            end else begin
               // zero weight in sum mode gives m/z 0
               pmz_in   = (mode_ff == MODE_MAX) ? best_mz_ff : '0;
               state_in = S_TOT;
            end
         end
         S_DIV: begin
            // restoring divide; the dividend shifts out as quotient shifts in
            rem_in      = div_ge ? alu_rsp.sum[PINT_W-1:0] : rem_shift[PINT_W-1:0];
            weighted_in = {weighted_ff[WACC_W-2:0], div_ge};
            if (cnt_ff == '0) begin
               // clamp to the m/z range
               if (|weighted_in[WACC_W-1:MZW]) begin
                  pmz_in = MZ_W'({MZW{1'b1}});
               end else begin
                  pmz_in = MZ_W'(weighted_in[MZW-1:0]);
               end
               state_in = S_TOT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_TOT: begin
            // emit only once the output register is free
            if (slot_free) begin
               total_in    = sum_ovf48 ? {TOTAL_W{1'b1}} : alu_rsp.sum[TOTAL_W-1:0];
               max_seen_in = (best_ff > max_seen_ff) ? best_ff : max_seen_ff;
               o_idx_in    = SCAN_OUT_W'(idx_ff);
               o_rt_in     = rt_ff;
               o_pint_in   = best_ff;
               o_pmz_in    = pmz_ff;
               o_total_in  = total_in;
               o_max_in    = max_seen_in;
               o_sat_in    = sat_ff | sum_ovf48;
               rsp_valid_in = 1'b1;
               best_in     = '0;
               best_mz_in  = '0;
               weighted_in = '0;
               sat_in      = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mz_low_ff    <= '0;
         mz_high_ff   <= {MZ_W{1'b1}};
         rt_low_ff    <= '0;
         rt_high_ff   <= {RT_W{1'b1}};
         ms_level_ff  <= LEVEL_W'(1);
         mode_ff      <= MODE_MAX;
         counter_ff   <= '0;
         best_ff      <= '0;
         best_mz_ff   <= '0;
         weighted_ff  <= '0;
         total_ff     <= '0;
         max_seen_ff  <= '0;
         stopped_ff   <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mz_low_ff    <= mz_low_in;
         mz_high_ff   <= mz_high_in;
         rt_low_ff    <= rt_low_in;
         rt_high_ff   <= rt_high_in;
         ms_level_ff  <= ms_level_in;
         mode_ff      <= mode_in;
         counter_ff   <= counter_in;
         best_ff      <= best_in;
         best_mz_ff   <= best_mz_in;
         weighted_ff  <= weighted_in;
         total_ff     <= total_in;
         max_seen_ff  <= max_seen_in;
         stopped_ff   <= stopped_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      has_peak_ff <= has_peak_in;
      mz_ff       <= mz_in;
      inten_ff    <= inten_in;
      rt_ff       <= rt_in;
      level_ff    <= level_in;
      end_ff      <= end_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      pmz_ff      <= pmz_in;
      o_idx_ff    <= o_idx_in;
      o_rt_ff     <= o_rt_in;
      o_pint_ff   <= o_pint_in;
      o_pmz_ff    <= o_pmz_in;
      o_total_ff  <= o_total_in;
      o_max_ff    <= o_max_in;
      o_sat_ff    <= o_sat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_scan_index      = o_idx_ff;
   assign rsp_point_rt        = o_rt_ff;
   assign rsp_point_intensity = o_pint_ff;
   assign rsp_point_mz        = o_pmz_ff;
   assign rsp_running_total   = o_total_ff;
   assign rsp_running_max     = o_max_ff;
   assign rsp_saturated       = o_sat_ff;

   // running total only grows between resets
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("running total decreased");

   // the shown running max covers the shown point
   a_max_covers_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> o_max_ff >= o_pint_ff)
      else $error("running max below point intensity");

   // stopped block never leaves idle
   a_stopped_idle: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> state_ff == S_IDLE)
      else $error("stopped block left idle");

   // division only runs in sum mode with a nonzero divisor
   a_div_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> (mode_ff == MODE_SUM) && (best_ff != '0))
      else $error("division with zero divisor or in max mode");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ion chromatogram slice
// Streams directed and random scans of centroids, predicts each trace point
// from a cycle-free model of the reduction, and checks every emitted point
// field by field under varying input gaps and output backpressure.
// ----------------------------------------------------------------------------
module tb;
   import ics_pkg::*;

   // Worst case per item is a sum-mode multiply plus the scan-end division;
   // the settle window leaves margin over that.
   localparam int QUIET_CYCLES   = 160;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;

   localparam logic [MZ_W-1:0]    MZ_TOP    = '1;
   localparam logic [INT_W-1:0]   INT_TOP   = '1;
   localparam logic [RT_W-1:0]    RT_TOP    = '1;
   localparam logic [PINT_W-1:0]  PINT_TOP  = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_TOP = '1;
   localparam logic [WACC_W-1:0]  WACC_TOP  = '1;

   typedef struct packed {
      logic [SCAN_OUT_W-1:0] scan_index;
      logic [RT_W-1:0]       point_rt;
      logic [PINT_W-1:0]     point_intensity;
      logic [MZ_W-1:0]       point_mz;
      logic [TOTAL_W-1:0]    running_total;
      logic [PINT_W-1:0]     running_max;
      logic                  saturated;
   } trace_point_t;

   // ------------------------------------------------------------------------
   // clock, reset and block ports; every input known from time zero
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic                  req_has_peak       = 1'b0;
   logic [MZ_W-1:0]       req_peak_mz        = '0;
   logic [INT_W-1:0]      req_peak_intensity = '0;
   logic [RT_W-1:0]       req_scan_rt        = '0;
   logic [LEVEL_W-1:0]    req_scan_level     = '0;
   logic                  req_scan_end       = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [SCAN_OUT_W-1:0] rsp_scan_index;
   logic [RT_W-1:0]       rsp_point_rt;
   logic [PINT_W-1:0]     rsp_point_intensity;
   logic [MZ_W-1:0]       rsp_point_mz;
   logic [TOTAL_W-1:0]    rsp_running_total;
   logic [PINT_W-1:0]     rsp_running_max;
   logic                  rsp_saturated;

   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index          = '0;
   logic [CSR_DATA_W-1:0] csr_data           = '0;

   ion_chromatogram_slice u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_has_peak        (req_has_peak),
      .req_peak_mz         (req_peak_mz),
      .req_peak_intensity  (req_peak_intensity),
      .req_scan_rt         (req_scan_rt),
      .req_scan_level      (req_scan_level),
      .req_scan_end        (req_scan_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_scan_index      (rsp_scan_index),
      .rsp_point_rt        (rsp_point_rt),
      .rsp_point_intensity (rsp_point_intensity),
      .rsp_point_mz        (rsp_point_mz),
      .rsp_running_total   (rsp_running_total),
      .rsp_running_max     (rsp_running_max),
      .rsp_saturated       (rsp_saturated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // register mirror and prediction state, all at reset values
   // ------------------------------------------------------------------------
   logic [MZ_W-1:0]       win_mz_low  = '0;
   logic [MZ_W-1:0]       win_mz_high = MZ_TOP;
   logic [RT_W-1:0]       win_rt_low  = '0;
   logic [RT_W-1:0]       win_rt_high = RT_TOP;
   logic [LEVEL_W-1:0]    win_level   = 4'd1;
   logic                  win_mode    = MODE_MAX;

   logic [SCAN_OUT_W-1:0] scan_count  = '0;
   logic [PINT_W-1:0]     best_int    = '0;   // max, or running sum in sum mode
   logic [MZ_W-1:0]       best_mz     = '0;
   logic [WACC_W-1:0]     weight_acc  = '0;   // sum of mz * intensity
   logic [TOTAL_W-1:0]    total_acc   = '0;
   logic [PINT_W-1:0]     max_point   = '0;
   logic                  halted      = 1'b0;
   logic                  scan_sat    = 1'b0;

   trace_point_t          pending_points[$];

   int                    mismatches    = 0;
   int                    send_idle_pct = 0;
   int                    stall_pct     = 0;
   int                    hold_request  = 0;
   int                    quiet_count   = 0;

   function automatic void clear_scan_acc();
      best_int   = '0;
      best_mz    = '0;
      weight_acc = '0;
      scan_sat   = 1'b0;
   endfunction

   // Fold one accepted item into the per-scan reduction. At a scan end the
   // scan is counted and, if it passes the level and rt window, a point is
   // queued. A scan at the window level beyond the rt upper limit freezes the predictor.
   task automatic fold_centroid(input logic has_peak, input logic [MZ_W-1:0] mz,
                                input logic [INT_W-1:0] inten, input logic [RT_W-1:0] rt,
                                input logic [LEVEL_W-1:0] level, input logic scan_end);
      logic [PINT_W:0]   int_sum;
      logic [WACC_W:0]   weight_sum;
      logic [TOTAL_W:0]  grand_sum;
      logic [WACC_W-1:0] mean_mz;
      trace_point_t      pt;
      if (halted)
         return;
      // mode is taken per item, so a mid-scan switch mixes the two rules
      if (has_peak && mz >= win_mz_low && mz <= win_mz_high) begin
         if (win_mode == MODE_MAX) begin
            if (inten > best_int) begin   // strict: first of equals wins
               best_int = inten;
               best_mz  = mz;
            end
         end else begin
            int_sum = {1'b0, best_int} + inten;
            if (int_sum[PINT_W]) begin
               best_int = PINT_TOP;
               scan_sat = 1'b1;
            end else begin
               best_int = int_sum[PINT_W-1:0];
            end
            if (inten != '0) begin
               weight_sum = {1'b0, weight_acc} + (WACC_W'(mz) * WACC_W'(inten));
               if (weight_sum[WACC_W]) begin
                  weight_acc = WACC_TOP;
                  scan_sat   = 1'b1;
               end else begin
                  weight_acc = weight_sum[WACC_W-1:0];
               end
            end
         end
      end
      if (!scan_end)
         return;
      pt.scan_index = scan_count;
      scan_count    = scan_count + 1'b1;
      // the end item's level and rt decide for the whole scan
      if (level != win_level || rt < win_rt_low) begin
         clear_scan_acc();
         return;
      end
      if (rt > win_rt_high) begin
         halted = 1'b1;
         clear_scan_acc();
         return;
      end
      pt.point_rt        = rt;
      pt.point_intensity = best_int;
      pt.saturated       = scan_sat;
      if (win_mode == MODE_MAX) begin
         pt.point_mz = best_mz;
      end else begin
         // zero weight gives mz 0; clamp only matters with a saturated sum
         if (best_int == '0)
            mean_mz = '0;
         else
            mean_mz = weight_acc / WACC_W'(best_int);
         pt.point_mz = (mean_mz > WACC_W'(MZ_TOP)) ? MZ_TOP : mean_mz[MZ_W-1:0];
      end
      grand_sum = {1'b0, total_acc} + best_int;
      if (grand_sum[TOTAL_W]) begin
         total_acc    = TOTAL_TOP;
         pt.saturated = 1'b1;
      end else begin
         total_acc = grand_sum[TOTAL_W-1:0];
      end
      if (best_int > max_point)
         max_point = best_int;
      pt.running_total = total_acc;
      pt.running_max   = max_point;
      pending_points.push_back(pt);
      clear_scan_acc();
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // monitor: all three channels sampled at the clock edge. Results are
   // checked before the same edge's item is folded, so a new point can
   // never be matched against its own expectation in the same cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : point_monitor
      trace_point_t want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_points.size() == 0) begin
               report_mismatch("unexpected point, scan_index", rsp_scan_index, 0);
            end else begin
               want = pending_points.pop_front();
               if (rsp_scan_index !== want.scan_index)
                  report_mismatch("scan_index", rsp_scan_index, want.scan_index);
               if (rsp_point_rt !== want.point_rt)
                  report_mismatch("point_rt", rsp_point_rt, want.point_rt);
               if (rsp_point_intensity !== want.point_intensity)
                  report_mismatch("point_intensity", rsp_point_intensity,
                                  want.point_intensity);
               if (rsp_point_mz !== want.point_mz)
                  report_mismatch("point_mz", rsp_point_mz, want.point_mz);
               if (rsp_running_total !== want.running_total)
                  report_mismatch("running_total", rsp_running_total, want.running_total);
               if (rsp_running_max !== want.running_max)
                  report_mismatch("running_max", rsp_running_max, want.running_max);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", rsp_saturated, want.saturated);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MZ_LOW:   win_mz_low  = csr_data[MZ_W-1:0];
               CSR_MZ_HIGH:  win_mz_high = csr_data[MZ_W-1:0];
               CSR_RT_LOW:   win_rt_low  = csr_data[RT_W-1:0];
               CSR_RT_HIGH:  win_rt_high = csr_data[RT_W-1:0];
               CSR_MS_LEVEL: win_level   = csr_data[LEVEL_W-1:0];
               CSR_MODE:     win_mode    = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            fold_centroid(req_has_peak, req_peak_mz, req_peak_intensity, req_scan_rt,
                          req_scan_level, req_scan_end);
      end
   end

   // Receiver: random stalls, or a long hold-off when a test asks for one.
   always @(posedge clock) begin : point_receiver
      int hold_left;
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_count <= 0;
      end else begin
         quiet_count <= quiet_count + 1;
         if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("FAIL ion_chromatogram_slice");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // One centroid item. Valid is only dropped when a gap is taken, so a
   // back-to-back item never lowers and raises valid in one step.
   task automatic send_centroid(input logic has_peak, input logic [MZ_W-1:0] mz,
                                input logic [INT_W-1:0] inten, input logic [RT_W-1:0] rt,
                                input logic [LEVEL_W-1:0] level, input logic scan_end);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_has_peak       <= has_peak;
      req_peak_mz        <= mz;
      req_peak_intensity <= inten;
      req_scan_rt        <= rt;
      req_scan_level     <= level;
      req_scan_end       <= scan_end;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering items and wait for every queued point to come out.
   task automatic settle_points();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Registers change only with the block idle: points drained, then a
   // pause long enough for a resultless item still in flight to finish.
   task automatic configure(input logic [MZ_W-1:0] mz_lo, input logic [MZ_W-1:0] mz_hi,
                            input logic [RT_W-1:0] rt_lo, input logic [RT_W-1:0] rt_hi,
                            input logic [LEVEL_W-1:0] lvl, input logic md);
      settle_points();
      repeat (QUIET_CYCLES) @(posedge clock);
      write_reg(CSR_MZ_LOW,   CSR_DATA_W'(mz_lo));
      write_reg(CSR_MZ_HIGH,  CSR_DATA_W'(mz_hi));
      write_reg(CSR_RT_LOW,   CSR_DATA_W'(rt_lo));
      write_reg(CSR_RT_HIGH,  CSR_DATA_W'(rt_hi));
      write_reg(CSR_MS_LEVEL, CSR_DATA_W'(lvl));
      write_reg(CSR_MODE,     CSR_DATA_W'(md));
      csr_valid <= 1'b0;
   endtask

   // One well-formed scan with random content. Mostly it passes the level
   // and rt filters; some scans miss the level or fall below rt_low. Extra
   // has_peak 0 items in mid-scan are noise and are not counted.
   task automatic send_random_scan(inout int counted);
      int                 n_peaks;
      int                 pick;
      logic               trailing;
      logic               last;
      logic [RT_W-1:0]    end_rt;
      logic [LEVEL_W-1:0] end_level;
      logic [MZ_W-1:0]    mz;
      logic [INT_W-1:0]   inten;
      n_peaks   = $urandom_range(0, 6);
      end_level = ($urandom_range(0, 99) < 80) ? win_level : LEVEL_W'($urandom_range(0, 15));
      if (end_level != win_level)
         end_rt = RT_W'($urandom);   // may lie past rt_high: must not halt
      else if (win_rt_low != '0 && $urandom_range(0, 99) < 10)
         end_rt = RT_W'($urandom_range(0, win_rt_low - 1));
      else
         end_rt = RT_W'($urandom_range(win_rt_low, win_rt_high));
      trailing = (n_peaks == 0) || ($urandom_range(0, 9) == 0);
      for (int k = 0; k < n_peaks; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_centroid(1'b0, MZ_W'($urandom), $urandom, RT_W'($urandom),
                          LEVEL_W'($urandom), 1'b0);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            mz = MZ_W'($urandom_range(win_mz_low, win_mz_high));
         else if (pick < 85)
            mz = MZ_W'($urandom);
         else
            case (pick % 4)
               0:       mz = win_mz_low;
               1:       mz = win_mz_high;
               2:       mz = win_mz_low - 1'b1;
               default: mz = win_mz_high + 1'b1;
            endcase
         pick = $urandom_range(0, 99);
         if (pick < 10)
            inten = '0;
         else if (pick < 20)
            inten = INT_TOP;
         else if (pick < 50)
            inten = INT_W'($urandom_range(0, 1000));
         else
            inten = $urandom;
         last = (k == n_peaks - 1) && !trailing;
         send_centroid(1'b1, mz, inten, last ? end_rt : RT_W'($urandom),
                       last ? end_level : LEVEL_W'($urandom), last);
         counted++;
      end
      if (trailing) begin
         send_centroid(1'b0, MZ_W'($urandom), $urandom, end_rt, end_level, 1'b1);
         counted++;
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // Reset settings: full window, level 1, max mode. Field extremes, tie on
   // intensity, empty scan, has_peak 0 ignoring its fields, level miss.
   task automatic test_max_mode();
      send_idle_pct = 20;
      stall_pct     = 20;
      send_centroid(1'b1, '0, '0, 24'd10, 4'd1, 1'b0);
      send_centroid(1'b1, MZ_TOP, INT_TOP, 24'd10, 4'd1, 1'b0);
      send_centroid(1'b1, 28'd5, INT_TOP, 24'd10, 4'd1, 1'b0);
      send_centroid(1'b1, 28'd7, 32'd100, 24'd10, 4'd1, 1'b1);
      send_centroid(1'b0, '0, '0, 24'd20, 4'd1, 1'b1);
      send_centroid(1'b0, MZ_TOP, INT_TOP, RT_TOP, 4'd15, 1'b0);
      send_centroid(1'b1, 28'd3, 32'd9, 24'd25, 4'd1, 1'b1);
      send_centroid(1'b1, 28'd4, 32'd50, 24'd30, 4'd2, 1'b1);
   endtask

   // Inclusive m/z and rt edges, a scan with nothing in window, a level miss
   // beyond rt_high that must not halt, then both windows at their tops.
   task automatic test_window_edges();
      configure(28'd1000, 28'd2000, 24'd1000, 24'd5000, 4'd2, MODE_MAX);
      send_centroid(1'b1, 28'd999, 32'd900, 24'd1000, 4'd2, 1'b0);
      send_centroid(1'b1, 28'd1000, 32'd10, 24'd1000, 4'd2, 1'b0);
      send_centroid(1'b1, 28'd2000, 32'd20, 24'd1000, 4'd2, 1'b0);
      send_centroid(1'b1, 28'd2001, 32'd900, 24'd1000, 4'd2, 1'b1);
      send_centroid(1'b1, 28'd1500, 32'd5, 24'd999, 4'd2, 1'b1);
      send_centroid(1'b1, 28'd3000, 32'd7, 24'd5000, 4'd2, 1'b1);
      send_centroid(1'b0, '0, '0, 24'd6000, 4'd3, 1'b1);
      send_centroid(1'b1, 28'd1500, 32'd1, 24'd5000, 4'd2, 1'b1);
      configure(MZ_TOP, MZ_TOP, RT_TOP, RT_TOP, 4'd15, MODE_MAX);
      send_centroid(1'b1, MZ_TOP - 1'b1, 32'd3, RT_TOP, 4'd15, 1'b0);
      send_centroid(1'b1, MZ_TOP, 32'd4, RT_TOP, 4'd15, 1'b1);
      send_centroid(1'b0, '0, '0, '0, 4'd15, 1'b1);
   endtask

   // Sum mode: weighted mean with floor, zero weight, empty scan.
   task automatic test_sum_mode();
      configure('0, MZ_TOP, '0, RT_TOP, 4'd1, MODE_SUM);
      send_centroid(1'b1, 28'd100, 32'd3, 24'd50, 4'd1, 1'b0);
      send_centroid(1'b1, 28'd200, 32'd1, 24'd50, 4'd1, 1'b1);
      send_centroid(1'b1, MZ_TOP, '0, 24'd60, 4'd1, 1'b1);
      send_centroid(1'b0, '0, '0, 24'd70, 4'd1, 1'b1);
      send_centroid(1'b1, 28'd7, 32'd1, 24'd80, 4'd1, 1'b0);
      send_centroid(1'b1, 28'd8, 32'd1, 24'd80, 4'd1, 1'b1);
      send_centroid(1'b1, MZ_TOP, INT_TOP, 24'd90, 4'd1, 1'b1);
   endtask

   // Mode flips with a scan half sent; the scan mixes both rules.
   task automatic test_mode_switch();
      configure('0, MZ_TOP, '0, RT_TOP, 4'd1, MODE_MAX);
      send_centroid(1'b1, 28'd10, 32'd5, 24'd100, 4'd1, 1'b0);
      send_centroid(1'b1, 28'd20, 32'd9, 24'd100, 4'd1, 1'b0);
      configure('0, MZ_TOP, '0, RT_TOP, 4'd1, MODE_SUM);
      send_centroid(1'b1, 28'd30, 32'd1, 24'd100, 4'd1, 1'b1);
      send_centroid(1'b1, 28'd50, 32'd4, 24'd110, 4'd1, 1'b0);
      configure('0, MZ_TOP, '0, RT_TOP, 4'd1, MODE_MAX);
      send_centroid(1'b1, 28'd60, 32'd3, 24'd110, 4'd1, 1'b1);
   endtask

   // Weighted sum overflows after 17 top-valued centroids; the intensity
   // sum needs 257 full-scale ones before it clamps at 40 bits.
   task automatic test_saturation();
      configure('0, MZ_TOP, '0, RT_TOP, 4'd1, MODE_SUM);
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int k = 0; k < 17; k++)
         send_centroid(1'b1, MZ_TOP, INT_TOP, 24'd200, 4'd1, k == 16);
      for (int k = 0; k < 260; k++)
         send_centroid(1'b1, 28'd1, INT_TOP, 24'd210, 4'd1, k == 259);
   endtask

   // Four idling profiles, each with its own register set; across the phases
   // the ms level reaches 0 and 15 and both modes run.
   task automatic test_random_phases();
      int               counted;
      logic [MZ_W-1:0]  lo;
      logic [RT_W-1:0]  rlo;
      // no idling, full ranges so every input bit toggles
      configure('0, MZ_TOP, '0, RT_TOP, 4'd1, MODE_MAX);
      send_idle_pct = 0;
      stall_pct     = 0;
      counted       = 0;
      while (counted < 200) send_random_scan(counted);
      // sender mostly idle, random windows, level 0, sum mode
      lo  = MZ_W'($urandom_range(0, 1 << 27));
      rlo = RT_W'($urandom_range(0, 1 << 23));
      configure(lo, lo + MZ_W'($urandom_range(0, (1 << 27) - 1)), rlo,
                rlo + RT_W'($urandom_range(0, (1 << 23) - 1)), 4'd0, MODE_SUM);
      send_idle_pct = 79;
      stall_pct     = 0;
      counted       = 0;
      while (counted < 200) send_random_scan(counted);
      // receiver mostly stalled, narrow window, level 15, max mode
      lo = MZ_W'($urandom_range(0, MZ_TOP - 256));
      configure(lo, lo + MZ_W'($urandom_range(0, 255)), RT_W'($urandom_range(0, 1000)),
                RT_TOP, 4'd15, MODE_MAX);
      send_idle_pct = 0;
      stall_pct     = 79;
      counted       = 0;
      while (counted < 200) send_random_scan(counted);
      // light idling on both sides, random level, sum mode
      configure('0, MZ_TOP, '0, RT_TOP, LEVEL_W'($urandom_range(0, 15)), MODE_SUM);
      send_idle_pct = 6;
      stall_pct     = 6;
      counted       = 0;
      while (counted < 200) send_random_scan(counted);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   // scans back to back, so the output register fills and input stalls.
   task automatic test_backpressure();
      configure('0, MZ_TOP, '0, RT_TOP, 4'd1, MODE_MAX);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = HOLD_CYCLES;
      for (int k = 0; k < 40; k++) begin
         send_centroid(1'b1, MZ_W'($urandom), $urandom, RT_W'(k), 4'd1, 1'b0);
         send_centroid(1'b1, MZ_W'($urandom), $urandom, RT_W'(k), 4'd1, 1'b1);
      end
   endtask

   // Last, since only reset clears it: rt_high at 0, a scan past it halts
   // the block and every later item, even a passing one, is dropped.
   task automatic test_halt();
      configure('0, MZ_TOP, '0, '0, 4'd1, MODE_MAX);
      send_idle_pct = 20;
      stall_pct     = 20;
      send_centroid(1'b1, 28'd11, 32'd22, 24'd0, 4'd1, 1'b1);
      send_centroid(1'b0, '0, '0, 24'd5, 4'd2, 1'b1);
      send_centroid(1'b1, 28'd12, 32'd33, 24'd1, 4'd1, 1'b1);
      for (int k = 0; k < 6; k++)
         send_centroid(1'b1, MZ_W'($urandom), $urandom, 24'd0, 4'd1, 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_max_mode();
      test_window_edges();
      test_sum_mode();
      test_mode_switch();
      test_saturation();
      test_random_phases();
      test_backpressure();
      test_halt();
      settle_points();
      repeat (QUIET_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS ion_chromatogram_slice");
      else
         $display("FAIL ion_chromatogram_slice");
      $finish;
   end

endmodule
